// File: rtl/core/etrs_pkg.sv
// ----------------------------------------------------------------------------
// etrs_pkg
// Shared widths, types and the quarter-wave sine table builder for the
// Euler ZYX transform builder.
// ----------------------------------------------------------------------------
package etrs_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int TABLE_BITS_DEF = 10;

   localparam int ANGLE_W = 16;
   localparam int TRIG_W  = 16;
   localparam int SCALE_W = 24;
   localparam int POS_W   = 32;
   localparam int PROD_W  = 32;
   localparam int ROT_W   = 33;
   localparam int SPROD_W = ROT_W + SCALE_W;
   localparam int ROT_N   = 9;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SIN_DIV [10] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                           64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

   typedef struct packed {
      logic signed [TRIG_W-1:0] s;
      logic signed [TRIG_W-1:0] c;
   } trig_type;

   typedef struct packed {
      logic signed [SCALE_W-1:0] scale_x;
      logic signed [SCALE_W-1:0] scale_y;
      logic signed [SCALE_W-1:0] scale_z;
      logic signed [POS_W-1:0]   pos_x;
      logic signed [POS_W-1:0]   pos_y;
      logic signed [POS_W-1:0]   pos_z;
   } side_type;

   // round(32767*sin(i*(pi/2)/2^tb)) by integer series
   function automatic logic [15:0] sin_entry(input int unsigned i, input int unsigned tb);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        v;
      if (i >= (32'd1 << tb)) begin
         return 16'd32767;
      end
      x    = (64'(i) * HALF_PI_Q30) >> tb;
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int k = 1; k <= 10; k++) begin
         term = (term * x2) >> 30;
         term = term / SIN_DIV[k-1];
         if ((k & 1) != 0) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      v = (unsigned'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[15:0];
   endfunction

endpackage

// File: rtl/core/etrs_trig_lane.sv
// ----------------------------------------------------------------------------
// etrs_trig_lane
// Sine and cosine of one binary angle from a quarter-wave table, registered.
// ----------------------------------------------------------------------------
module etrs_trig_lane
   import etrs_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int TABLE_BITS = TABLE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [ANGLE_BITS-1:0] angle,
   output trig_type              trig_ff
);

   localparam int FB    = ANGLE_BITS - 2;
   localparam int TAB_N = 1 << TABLE_BITS;

   logic [15:0]           tab [TAB_N+1];
   logic [1:0]            qs;
   logic [1:0]            qc;
   logic [TABLE_BITS-1:0] idx;
   logic [TABLE_BITS:0]   idx_s;
   logic [TABLE_BITS:0]   idx_c;
   logic [15:0]           vs;
   logic [15:0]           vc;
   trig_type              trig_in;

   for (genvar g = 0; g <= TAB_N; g++) begin : g_tab
      localparam logic [15:0] ENT = sin_entry(g, TABLE_BITS);
      assign tab[g] = ENT;
   end

   if (FB >= TABLE_BITS) begin : g_trunc
      assign idx = angle[FB-1 -: TABLE_BITS];
   end else begin : g_pad
      assign idx = {angle[FB-1:0], (TABLE_BITS-FB)'(0)};
   end

   assign qs = angle[ANGLE_BITS-1 -: 2];
   assign qc = qs + 2'd1;

   always_comb begin
      idx_s = qs[0] ? (TABLE_BITS+1)'(TAB_N) - {1'b0, idx} : {1'b0, idx};
      idx_c = qc[0] ? (TABLE_BITS+1)'(TAB_N) - {1'b0, idx} : {1'b0, idx};
      vs = tab[idx_s];
      vc = tab[idx_c];
      trig_in.s = qs[1] ? -signed'(vs) : signed'(vs);
      trig_in.c = qc[1] ? -signed'(vc) : signed'(vc);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

endmodule

// File: rtl/core/etrs_rot_merge.sv
// ----------------------------------------------------------------------------
// etrs_rot_merge
// Combine the three trig lanes into the nine Q30 rotation entries over
// three pipeline stages.
// ----------------------------------------------------------------------------
module etrs_rot_merge
   import etrs_pkg::*;
(
   input  logic                    clock,
   input  logic                    en,
   input  trig_type                tx,
   input  trig_type                ty,
   input  trig_type                tz,
   output logic signed [ROT_W-1:0] rot_ff [ROT_N]
);

   logic signed [PROD_W-1:0] sxsy_ff, cxsy_ff, cycz_ff, cxsz_ff, sxsz_ff;
   logic signed [PROD_W-1:0] cysz_ff, cxcz_ff, sxcz_ff, sxcy_ff, cxcy_ff;
   logic signed [TRIG_W-1:0] cz_ff, sz_ff, sy_ff;

   logic signed [TRIG_W-1:0] sxsy_r, cxsy_r;
   logic signed [PROD_W-1:0] sy_ext;
   logic signed [PROD_W-1:0] a_ff, b_ff, c_ff, d_ff, negsy_ff;
   logic signed [PROD_W-1:0] cycz2_ff, cxsz2_ff, sxsz2_ff, cysz2_ff, cxcz2_ff;
   logic signed [PROD_W-1:0] sxcz2_ff, sxcy2_ff, cxcy2_ff;
   logic signed [ROT_W-1:0]  rot_in [ROT_N];

   always_ff @(posedge clock) begin
      if (en) begin
         sxsy_ff <= tx.s * ty.s;
         cxsy_ff <= tx.c * ty.s;
         cycz_ff <= ty.c * tz.c;
         cxsz_ff <= tx.c * tz.s;
         sxsz_ff <= tx.s * tz.s;
         cysz_ff <= ty.c * tz.s;
         cxcz_ff <= tx.c * tz.c;
         sxcz_ff <= tx.s * tz.c;
         sxcy_ff <= tx.s * ty.c;
         cxcy_ff <= tx.c * ty.c;
         cz_ff   <= tz.c;
         sz_ff   <= tz.s;
         sy_ff   <= ty.s;
      end
   end

   always_comb begin
      sxsy_r = TRIG_W'((sxsy_ff + 32'sd16384) >>> 15);
      cxsy_r = TRIG_W'((cxsy_ff + 32'sd16384) >>> 15);
      sy_ext = PROD_W'(sy_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= sxsy_r * cz_ff;
         b_ff     <= cxsy_r * cz_ff;
         c_ff     <= sxsy_r * sz_ff;
         d_ff     <= cxsy_r * sz_ff;
         negsy_ff <= -(sy_ext <<< 15);
         cycz2_ff <= cycz_ff;
         cxsz2_ff <= cxsz_ff;
         sxsz2_ff <= sxsz_ff;
         cysz2_ff <= cysz_ff;
         cxcz2_ff <= cxcz_ff;
         sxcz2_ff <= sxcz_ff;
         sxcy2_ff <= sxcy_ff;
         cxcy2_ff <= cxcy_ff;
      end
   end

   always_comb begin
      rot_in[0] = ROT_W'(cycz2_ff);
      rot_in[1] = ROT_W'(a_ff) - ROT_W'(cxsz2_ff);
      rot_in[2] = ROT_W'(b_ff) + ROT_W'(sxsz2_ff);
      rot_in[3] = ROT_W'(cysz2_ff);
      rot_in[4] = ROT_W'(c_ff) + ROT_W'(cxcz2_ff);
      rot_in[5] = ROT_W'(d_ff) - ROT_W'(sxcz2_ff);
      rot_in[6] = ROT_W'(negsy_ff);
      rot_in[7] = ROT_W'(sxcy2_ff);
      rot_in[8] = ROT_W'(cxcy2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_ff <= rot_in;
      end
   end

endmodule

// File: rtl/core/etrs_scale_lane.sv
// ----------------------------------------------------------------------------
// etrs_scale_lane
// Scale one Q30 rotation entry by a Q8.16 axis scale, round and saturate.
// ----------------------------------------------------------------------------
module etrs_scale_lane
   import etrs_pkg::*;
(
   input  logic                      clock,
   input  logic                      en,
   input  logic signed [ROT_W-1:0]   rot,
   input  logic signed [SCALE_W-1:0] scale,
   output logic signed [SCALE_W-1:0] y_ff
);

   localparam int SH_W = SPROD_W + 1 - 30;

   logic signed [SPROD_W-1:0] prod_ff;
   logic signed [SPROD_W:0]   biased;
   logic signed [SH_W-1:0]    sh;
   logic signed [SCALE_W-1:0] y_in;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= rot * scale;
      end
   end

   always_comb begin
      biased = (SPROD_W+1)'(prod_ff) + (SPROD_W+1)'(64'sd536870912);
      sh     = SH_W'(biased >>> 30);
      if (sh > SH_W'(8388607)) begin
         y_in = SCALE_W'(8388607);
      end else if (sh < -SH_W'(8388608)) begin
         y_in = SCALE_W'(-8388608);
      end else begin
         y_in = SCALE_W'(sh);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff <= y_in;
      end
   end

endmodule

// File: rtl/core/euler_trs_matrix_builder_unit.sv
// ----------------------------------------------------------------------------
// euler_trs_matrix_builder_unit
// Builds the upper 3x4 of a column-major ZYX Euler transform with scaled
// columns and translation.
// ----------------------------------------------------------------------------
// The unit is a six-stage pipeline that takes one item per cycle while the
// output is not stalled: trig table lookup, two-factor products, three-factor
// products, entry sums, scale multiply, round and saturate. The first stage
// loads at the transfer edge and each later stage loads from the one before;
// a stalled result stalls the whole pipeline in place.
module euler_trs_matrix_builder_unit
   import etrs_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   parameter int TABLE_BITS = TABLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ANGLE_W-1:0]        req_angle_x,
   input  logic [ANGLE_W-1:0]        req_angle_y,
   input  logic [ANGLE_W-1:0]        req_angle_z,
   input  logic signed [SCALE_W-1:0] req_scale_x,
   input  logic signed [SCALE_W-1:0] req_scale_y,
   input  logic signed [SCALE_W-1:0] req_scale_z,
   input  logic signed [POS_W-1:0]   req_pos_x,
   input  logic signed [POS_W-1:0]   req_pos_y,
   input  logic signed [POS_W-1:0]   req_pos_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SCALE_W-1:0] rsp_col0_x,
   output logic signed [SCALE_W-1:0] rsp_col0_y,
   output logic signed [SCALE_W-1:0] rsp_col0_z,
   output logic signed [SCALE_W-1:0] rsp_col1_x,
   output logic signed [SCALE_W-1:0] rsp_col1_y,
   output logic signed [SCALE_W-1:0] rsp_col1_z,
   output logic signed [SCALE_W-1:0] rsp_col2_x,
   output logic signed [SCALE_W-1:0] rsp_col2_y,
   output logic signed [SCALE_W-1:0] rsp_col2_z,
   output logic signed [POS_W-1:0]   rsp_trans_x,
   output logic signed [POS_W-1:0]   rsp_trans_y,
   output logic signed [POS_W-1:0]   rsp_trans_z
);

   logic                      en;
   logic [5:0]                vld_ff;
   logic [5:0]                vld_in;
   side_type                  side_in;
   side_type                  side_ff [4];
   logic signed [POS_W-1:0]   p5x_ff, p5y_ff, p5z_ff;
   logic signed [POS_W-1:0]   p6x_ff, p6y_ff, p6z_ff;
   trig_type                  tx, ty, tz;
   logic signed [ROT_W-1:0]   rot [ROT_N];
   logic signed [SCALE_W-1:0] ent [ROT_N];
   logic signed [SCALE_W-1:0] lane_scale [ROT_N];

   assign en        = !vld_ff[5] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[5];
   assign vld_in    = {vld_ff[4:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   assign side_in = '{req_scale_x, req_scale_y, req_scale_z, req_pos_x, req_pos_y, req_pos_z};

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         side_ff[1] <= side_ff[0];
         side_ff[2] <= side_ff[1];
         side_ff[3] <= side_ff[2];
         p5x_ff     <= side_ff[3].pos_x;
         p5y_ff     <= side_ff[3].pos_y;
         p5z_ff     <= side_ff[3].pos_z;
         p6x_ff     <= p5x_ff;
         p6y_ff     <= p5y_ff;
         p6z_ff     <= p5z_ff;
      end
   end

   etrs_trig_lane #(.ANGLE_BITS(ANGLE_BITS), .TABLE_BITS(TABLE_BITS)) u_trig_x (
      .clock(clock), .en(en), .angle(ANGLE_BITS'(req_angle_x)), .trig_ff(tx));
   etrs_trig_lane #(.ANGLE_BITS(ANGLE_BITS), .TABLE_BITS(TABLE_BITS)) u_trig_y (
      .clock(clock), .en(en), .angle(ANGLE_BITS'(req_angle_y)), .trig_ff(ty));
   etrs_trig_lane #(.ANGLE_BITS(ANGLE_BITS), .TABLE_BITS(TABLE_BITS)) u_trig_z (
      .clock(clock), .en(en), .angle(ANGLE_BITS'(req_angle_z)), .trig_ff(tz));

   etrs_rot_merge u_merge (
      .clock(clock), .en(en), .tx(tx), .ty(ty), .tz(tz), .rot_ff(rot));

   always_comb begin
      for (int i = 0; i < ROT_N; i++) begin
         if (i < 3) begin
            lane_scale[i] = side_ff[3].scale_x;
         end else if (i < 6) begin
            lane_scale[i] = side_ff[3].scale_y;
         end else begin
            lane_scale[i] = side_ff[3].scale_z;
         end
      end
   end

   for (genvar g = 0; g < ROT_N; g++) begin : g_scale
      etrs_scale_lane u_scale (
         .clock(clock), .en(en), .rot(rot[g]), .scale(lane_scale[g]), .y_ff(ent[g]));
   end

   assign rsp_col0_x  = ent[0];
   assign rsp_col0_y  = ent[1];
   assign rsp_col0_z  = ent[2];
   assign rsp_col1_x  = ent[3];
   assign rsp_col1_y  = ent[4];
   assign rsp_col1_z  = ent[5];
   assign rsp_col2_x  = ent[6];
   assign rsp_col2_y  = ent[7];
   assign rsp_col2_z  = ent[8];
   assign rsp_trans_x = p6x_ff;
   assign rsp_trans_y = p6y_ff;
   assign rsp_trans_z = p6z_ff;

`ifndef SYNTHESIS
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted transfer did not enter the pipeline");
   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !req_ready |=> $stable(vld_ff))
      else $error("pipeline moved during stall");
   a_last_stage : assert property (@(posedge clock) disable iff (reset)
      (vld_ff[4] && req_ready) |=> rsp_valid)
      else $error("result lost at output stage");
`endif

endmodule
